>>> hw/rtl/sv32w_pkg.sv
package sv32w_pkg;

   typedef struct packed {
      logic        req_type;
      logic [31:0] vaddr;
      logic [1:0]  access_kind;
      logic [1:0]  priv_level;
      logic [31:0] pte_word;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  res_kind;
      logic [31:0] mem_addr;
      logic        set_dirty;
      logic [31:0] phys_addr;
      logic [2:0]  fault_code;
      logic        to_mmio;
      logic        last;
   } rsp_type;

   localparam logic [2:0] CSR_XLATE = 3'd0;
   localparam logic [2:0] CSR_ROOT  = 3'd1;
   localparam logic [2:0] CSR_SUM   = 3'd2;
   localparam logic [2:0] CSR_MXR   = 3'd3;
   localparam logic [2:0] CSR_BASE  = 3'd4;
   localparam logic [2:0] CSR_SIZE  = 3'd5;

   localparam logic [1:0] RK_READ = 2'd0;
   localparam logic [1:0] RK_AD   = 2'd1;
   localparam logic [1:0] RK_DONE = 2'd2;

   localparam logic [1:0] AK_FETCH = 2'd0;
   localparam logic [1:0] AK_LOAD  = 2'd1;
   localparam logic [1:0] AK_STORE = 2'd2;

   localparam logic [1:0] PL_USER = 2'd0;
   localparam logic [1:0] PL_MACH = 2'd2;

   localparam logic [2:0] FC_NONE = 3'd0;
   localparam logic [2:0] FC_ACC  = 3'd1;
   localparam logic [2:0] FC_PAGE = 3'd4;

   // item moved from the front part to the back part
   typedef struct packed {
      req_type_type item;
      logic         hit;
      logic [19:0]  hit_page;
      logic [9:0]   hit_flags;
   } cmd_type;

   typedef struct packed {
      logic        xlate;
      logic [21:0] root;
      logic        sum;
      logic        mxr;
      logic [31:0] base;
      logic [32:0] size;
   } cfg_type;

   typedef struct packed {
      logic        we;
      logic [19:0] vpn;
      logic [9:0]  flags;
      logic [19:0] page;
   } fill_type;

   function automatic logic in_ram(input logic [31:0] pa, input cfg_type c);
      logic [31:0] d;
      d = pa - c.base;
      return (pa >= c.base) && ({1'b0, d} < c.size);
   endfunction

   function automatic logic perm_ok(input logic [9:0] f, input logic [1:0] k,
                                    input logic [1:0] p, input cfg_type c);
      logic ok;
      if (f[4]) ok = !(p != PL_USER && (k == AK_FETCH || !c.sum));
      else      ok = (p != PL_USER);
      case (k)
         AK_FETCH: ok = ok & f[3];
         AK_LOAD:  ok = ok & (f[1] | (f[3] & c.mxr));
         default:  ok = ok & f[2];
      endcase
      return ok;
   endfunction

endpackage

>>> hw/rtl/sv32w_ram.sv
module sv32w_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

>>> hw/rtl/sv32w_front.sv
module sv32w_front import sv32w_pkg::*; #(
   parameter int TlbEntries = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_type_type in_item,
   output logic         in_ready,
   input  fill_type     fill,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_pop
);
   localparam int IW = (TlbEntries > 1) ? $clog2(TlbEntries) : 1;
   localparam int RD = (TlbEntries > 1) ? TlbEntries : 2;

   logic [IW-1:0] ridx, widx;
   logic [49:0]   rdata;
   logic [RD-1:0] valid_ff, valid_in;
   logic          vhit_ff, vhit_in;
   logic          stg_ff, stg_in;
   req_type_type  stg_item_ff;
   logic          q_ff, q_in;
   cmd_type       q_cmd_ff;
   cmd_type       made;

   assign ridx = IW'(in_item.vaddr[31:12] % TlbEntries);
   assign widx = IW'(fill.vpn % TlbEntries);

   // entry layout: tag, flags, page
   sv32w_ram #(.Width(50), .Depth(RD)) u_tlb (
      .clock(clock), .we(fill.we), .waddr(widx),
      .wdata({fill.vpn, fill.flags, fill.page}),
      .raddr(ridx), .rdata(rdata)
   );

   // one item in lookup at a time; queue holds one
   assign in_ready = !stg_ff && !q_ff;
   assign stg_in   = in_valid && in_ready;
   assign vhit_in  = valid_ff[ridx];

   always_comb begin
      made.item      = stg_item_ff;
      made.hit       = vhit_ff && rdata[49:30] == stg_item_ff.vaddr[31:12];
      made.hit_page  = rdata[19:0];
      made.hit_flags = rdata[29:20];
   end

   always_comb begin
      q_in = q_ff;
      if (cmd_pop) q_in = 1'b0;
      if (stg_ff)  q_in = 1'b1;
      valid_in = valid_ff;
      if (fill.we) valid_in[widx] = 1'b1;
   end

   assign cmd_valid = q_ff;
   assign cmd       = q_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff   <= 1'b0;
         q_ff     <= 1'b0;
         valid_ff <= '0;
      end else begin
         stg_ff   <= stg_in;
         q_ff     <= q_in;
         valid_ff <= valid_in;
      end
      if (stg_in) begin
         stg_item_ff <= in_item;
         vhit_ff     <= vhit_in;
      end
      if (stg_ff) q_cmd_ff <= made;
   end
endmodule

>>> hw/rtl/sv32w_back.sv
module sv32w_back import sv32w_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     cmd_valid,
   input  cmd_type  cmd,
   output logic     cmd_pop,
   output fill_type fill,
   output logic     rsp_valid,
   output rsp_type  rsp
);
   logic        busy_ff, busy_in, lvl_ff, lvl_in;
   logic [31:0] pva_ff, pva_in, ppte_ff, ppte_in;
   logic [1:0]  pacc_ff, pacc_in, ppriv_ff, ppriv_in;
   logic        second_ff, second_in;
   rsp_type     sec_ff, sec_in;
   logic        ov_ff, ov_in;
   rsp_type     o_ff, o_in;

   // the queue is not popped while a two-result item sends its second result
   assign cmd_pop = cmd_valid && !second_ff;

   always_comb begin
      logic [1:0]  k, p;
      logic [31:0] va, pte, addr, pa;
      logic [9:0]  fl;
      rsp_type     r;
      k = cmd.item.access_kind; p = cmd.item.priv_level;
      va = cmd.item.vaddr; pte = cmd.item.pte_word;
      if (k == 2'd3) k = AK_STORE;
      if (p == 2'd3) p = PL_MACH;
      busy_in = busy_ff; lvl_in = lvl_ff; pva_in = pva_ff; ppte_in = ppte_ff;
      pacc_in = pacc_ff; ppriv_in = ppriv_ff;
      second_in = 1'b0; sec_in = sec_ff;
      fill = '0;
      r = '0; r.res_kind = RK_DONE; r.last = 1'b1;
      ov_in = 1'b0;
      addr = '0; pa = '0; fl = '0;
      if (second_ff) begin
         ov_in = 1'b1; r = sec_ff;
      end else if (cmd_valid && !cmd.item.req_type) begin
         ov_in = 1'b1; busy_in = 1'b0; lvl_in = 1'b1;
         if (!cfg.xlate || p == PL_MACH) begin
            if (in_ram(va, cfg)) r.phys_addr = va;
            else if (k == AK_FETCH) r.fault_code = FC_ACC;
            else begin r.phys_addr = va; r.to_mmio = 1'b1; end
         end else if (k == AK_FETCH && cmd.hit) begin
            if (!perm_ok(cmd.hit_flags, AK_FETCH, p, cfg)) r.fault_code = FC_PAGE;
            else r.phys_addr = {cmd.hit_page, va[11:0]};
         end else begin
            pva_in = va; pacc_in = k; ppriv_in = p;
            addr = {cfg.root[19:0], 12'd0} + {20'd0, va[31:22], 2'b00};
            if (!in_ram(addr, cfg)) r.fault_code = FC_ACC + {1'b0, k};
            else begin
               busy_in = 1'b1; lvl_in = 1'b1; ppte_in = addr;
               r.res_kind = RK_READ; r.mem_addr = addr;
            end
         end
      end else if (cmd_valid && busy_ff) begin
         ov_in = 1'b1; busy_in = 1'b0; lvl_in = 1'b1;
         r.fault_code = FC_PAGE + {1'b0, pacc_ff};
         if (!pte[0] || (pte[2] && !pte[1])) begin
         end else if (pte[3:1] == 3'b000) begin
            if (lvl_ff) begin
               addr = {pte[29:10], 12'd0} + {20'd0, pva_ff[21:12], 2'b00};
               if (!in_ram(addr, cfg)) r.fault_code = FC_ACC + {1'b0, pacc_ff};
               else begin
                  busy_in = 1'b1; lvl_in = 1'b0; ppte_in = addr;
                  r = '0; r.res_kind = RK_READ; r.mem_addr = addr; r.last = 1'b1;
               end
            end
         end else if (lvl_ff && pte[19:10] != 10'd0) begin
         end else if (!perm_ok(pte[9:0], pacc_ff, ppriv_ff, cfg)) begin
         end else begin
            pa = lvl_ff ? {pte[29:20], pva_ff[21:0]} : {pte[29:10], pva_ff[11:0]};
            r.fault_code = FC_NONE;
            if (!in_ram(pa, cfg)) begin
               if (pacc_ff != AK_FETCH) begin r.phys_addr = pa; r.to_mmio = 1'b1; end
               else r.fault_code = FC_ACC;
            end else begin
               fl = pte[9:0] | 10'h40;
               if (pacc_ff == AK_STORE) fl = fl | 10'h80;
               fill.we = 1'b1; fill.vpn = pva_ff[31:12]; fill.flags = fl;
               fill.page = pa[31:12];
               r = '0; r.res_kind = RK_AD; r.mem_addr = ppte_ff;
               r.set_dirty = (pacc_ff == AK_STORE);
               second_in = 1'b1;
               sec_in = '0; sec_in.res_kind = RK_DONE; sec_in.phys_addr = pa;
               sec_in.last = 1'b1;
            end
         end
      end
      o_in = r;
   end

   assign rsp_valid = ov_ff;
   assign rsp       = o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; lvl_ff <= 1'b1; pva_ff <= '0; ppte_ff <= '0;
         pacc_ff <= '0; ppriv_ff <= '0; second_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; lvl_ff <= lvl_in; pva_ff <= pva_in; ppte_ff <= ppte_in;
         pacc_ff <= pacc_in; ppriv_ff <= ppriv_in; second_ff <= second_in;
         ov_ff <= ov_in;
      end
      sec_ff <= sec_in;
      o_ff   <= o_in;
   end
endmodule

>>> hw/rtl/sv32_page_walker_tlb_core.sv
// channel | direction | handshake         | payload
// req     | in        | start & !busy     | req_item (req_type_type)
// rsp     | out       | rsp_valid strobe  | rsp_item (rsp_type)
// csr     | in        | csr_valid & ready | csr_index, csr_data
// From start to its first result an item passes TLB read, queue and back part.
// A set A/D item gives its second result in the cycle after its first. busy stays
// high until the lookup stage and queue are empty; only then is a new item taken.
// Reset clears control and TLB valid bits, sets config defaults; no clearing pass.
// Results cannot be stalled.
module sv32_page_walker_tlb_core import sv32w_pkg::*; #(
   parameter int TLB_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [32:0]  csr_data
);
   cfg_type  cfg_ff, cfg_in;
   logic     in_ready, cmd_valid, cmd_pop;
   cmd_type  cmd;
   fill_type fill;

   assign busy      = !in_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_XLATE: cfg_in.xlate = csr_data[0];
            CSR_ROOT:  cfg_in.root  = csr_data[21:0];
            CSR_SUM:   cfg_in.sum   = csr_data[0];
            CSR_MXR:   cfg_in.mxr   = csr_data[0];
            CSR_BASE:  cfg_in.base  = csr_data[31:0];
            CSR_SIZE:  cfg_in.size  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{xlate: 1'b0, root: '0, sum: 1'b0, mxr: 1'b0,
                     base: 32'h8000_0000, size: 33'h0_0800_0000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sv32w_front #(.TlbEntries(TLB_ENTRIES)) u_front (
      .clock(clock), .reset(reset), .in_valid(start), .in_item(req_item),
      .in_ready(in_ready), .fill(fill), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_pop(cmd_pop)
   );

   sv32w_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_pop(cmd_pop), .fill(fill), .rsp_valid(rsp_valid), .rsp(rsp_item)
   );

   a_ad_then_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.res_kind == RK_AD |=> rsp_valid && rsp_item.last)
      else $error("A/D result not followed by final result");
   a_last_ad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.res_kind == RK_AD |-> !rsp_item.last)
      else $error("A/D result marked last");
   a_fill_once: assert property (@(posedge clock) disable iff (reset)
      fill.we |=> !fill.we)
      else $error("back to back TLB fills");
endmodule

>>> tb/sv/tb_sv32_page_walker_tlb_core.sv
`timescale 1ns / 1ps

module tb_sv32_page_walker_tlb_core;
   import sv32w_pkg::*;

   localparam int NUM_TLB    = 64;
   localparam int IDLE_LIMIT = 3000;
   localparam int ITEMS      = 650;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_item;
   logic         rsp_valid;
   rsp_type      rsp_item;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [32:0]  csr_data;

   sv32_page_walker_tlb_core #(.TLB_ENTRIES(NUM_TLB)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // predictor copy of translation state
   logic [19:0] tlb_vpn   [NUM_TLB];
   logic [9:0]  tlb_perm  [NUM_TLB];
   logic [19:0] tlb_ppn   [NUM_TLB];
   logic        walking;
   logic        wlevel;
   logic [31:0] walk_va;
   logic [1:0]  walk_kind;
   logic [1:0]  walk_priv;
   logic [31:0] walk_pte_addr;

   logic        xlate_on;
   logic [21:0] pt_root;
   logic        sum_en;
   logic        mxr_en;
   logic [31:0] ram_lo;
   logic [32:0] ram_len;

   rsp_type     exp_rsp_q[$];
   int          errors;
   int          sent;
   int          burst_left;
   int          idle_cycles;
   logic [31:0] fetch_pool[$];

   function automatic logic addr_in_ram(input logic [31:0] pa);
      logic [31:0] d;
      d = pa - ram_lo;
      return (pa >= ram_lo) && ({1'b0, d} < ram_len);
   endfunction

   function automatic logic access_allowed(input logic [9:0] f, input logic [1:0] k,
                                           input logic [1:0] p);
      logic ok;
      if (f[4]) ok = !(p != PL_USER && (k == AK_FETCH || !sum_en));
      else      ok = (p != PL_USER);
      if (k == AK_FETCH)     ok = ok && f[3];
      else if (k == AK_LOAD) ok = ok && (f[1] || (f[3] && mxr_en));
      else                   ok = ok && f[2];
      return ok;
   endfunction

   function automatic void push_rsp(input logic [1:0] kind, input logic [31:0] maddr,
                                    input logic dirty, input logic [31:0] pa,
                                    input logic [2:0] fault, input logic mmio,
                                    input logic lst);
      rsp_type r;
      r.res_kind   = kind;
      r.mem_addr   = maddr;
      r.set_dirty  = dirty;
      r.phys_addr  = pa;
      r.fault_code = fault;
      r.to_mmio    = mmio;
      r.last       = lst;
      exp_rsp_q.push_back(r);
   endfunction

   function automatic void walk_abort(input logic [2:0] code);
      walking = 1'b0;
      wlevel  = 1'b1;
      push_rsp(RK_DONE, 32'h0, 1'b0, 32'h0, code, 1'b0, 1'b1);
   endfunction

   function automatic void walk_read(input logic [31:0] addr, input logic lvl);
      if (!addr_in_ram(addr)) begin
         walk_abort(FC_ACC + {1'b0, walk_kind});
      end else begin
         walking       = 1'b1;
         wlevel        = lvl;
         walk_pte_addr = addr;
         push_rsp(RK_READ, addr, 1'b0, 32'h0, FC_NONE, 1'b0, 1'b1);
      end
   endfunction

   function automatic void walk_done(input logic [31:0] pa, input logic [31:0] pte);
      logic [19:0] vpn;
      logic [5:0]  idx;
      logic [9:0]  fl;
      vpn     = walk_va[31:12];
      idx     = vpn[5:0];
      walking = 1'b0;
      wlevel  = 1'b1;
      if (!addr_in_ram(pa)) begin
         if (walk_kind == AK_FETCH) push_rsp(RK_DONE, 32'h0, 1'b0, 32'h0, FC_ACC, 1'b0, 1'b1);
         else                       push_rsp(RK_DONE, 32'h0, 1'b0, pa, FC_NONE, 1'b1, 1'b1);
      end else begin
         fl    = pte[9:0] | 10'h040;
         if (walk_kind == AK_STORE) fl = fl | 10'h080;
         tlb_vpn[idx]  = vpn;
         tlb_perm[idx] = fl;
         tlb_ppn[idx]  = pa[31:12];
         push_rsp(RK_AD, walk_pte_addr, walk_kind == AK_STORE, 32'h0, FC_NONE, 1'b0, 1'b0);
         push_rsp(RK_DONE, 32'h0, 1'b0, pa, FC_NONE, 1'b0, 1'b1);
      end
   endfunction

   function automatic void predict_item(input req_type_type it);
      logic [1:0]  kind;
      logic [1:0]  priv;
      logic [19:0] vpn;
      logic [5:0]  idx;
      logic [31:0] va;
      logic [31:0] pte;
      logic [2:0]  pf;
      logic [31:0] pa;
      if (!it.req_type) begin
         va   = it.vaddr;
         kind = (it.access_kind == 2'd3) ? AK_STORE : it.access_kind;
         priv = (it.priv_level == 2'd3) ? PL_MACH : it.priv_level;
         walking = 1'b0;
         wlevel  = 1'b1;
         if (!xlate_on || priv == PL_MACH) begin
            if (addr_in_ram(va))
               push_rsp(RK_DONE, 32'h0, 1'b0, va, FC_NONE, 1'b0, 1'b1);
            else if (kind == AK_FETCH)
               push_rsp(RK_DONE, 32'h0, 1'b0, 32'h0, FC_ACC, 1'b0, 1'b1);
            else
               push_rsp(RK_DONE, 32'h0, 1'b0, va, FC_NONE, 1'b1, 1'b1);
            return;
         end
         vpn = va[31:12];
         idx = vpn[5:0];
         if (kind == AK_FETCH && tlb_perm[idx][0] && tlb_vpn[idx] == vpn) begin
            if (!access_allowed(tlb_perm[idx], AK_FETCH, priv))
               push_rsp(RK_DONE, 32'h0, 1'b0, 32'h0, FC_PAGE, 1'b0, 1'b1);
            else
               push_rsp(RK_DONE, 32'h0, 1'b0, {tlb_ppn[idx], va[11:0]}, FC_NONE, 1'b0, 1'b1);
            return;
         end
         walk_va   = va;
         walk_kind = kind;
         walk_priv = priv;
         walk_read({pt_root[19:0], 12'h0} + {20'h0, va[31:22], 2'b00}, 1'b1);
         return;
      end
      if (!walking) return;   // stray PTE word, dropped
      pte = it.pte_word;
      pf  = FC_PAGE + {1'b0, walk_kind};
      if (!pte[0] || (pte[2] && !pte[1])) begin
         walk_abort(pf);
      end else if (pte[3:1] == 3'b000) begin
         if (!wlevel) walk_abort(pf);
         else walk_read({pte[29:10], 12'h0} + {20'h0, walk_va[21:12], 2'b00}, 1'b0);
      end else if (wlevel && pte[19:10] != 10'h0) begin
         walk_abort(pf);   // misaligned superpage
      end else if (!access_allowed(pte[9:0], walk_kind, walk_priv)) begin
         walk_abort(pf);
      end else begin
         if (wlevel) pa = {pte[29:20], walk_va[21:0]};
         else        pa = {pte[29:10], walk_va[11:0]};
         walk_done(pa, pte);
      end
   endfunction

   // ---------------- stimulus helpers
   function automatic req_type_type xl_item(input logic [31:0] va, input logic [1:0] ak,
                                            input logic [1:0] pl);
      req_type_type it;
      it.req_type    = 1'b0;
      it.vaddr       = va;
      it.access_kind = ak;
      it.priv_level  = pl;
      it.pte_word    = $urandom;
      return it;
   endfunction

   function automatic req_type_type pte_item(input logic [31:0] w);
      req_type_type it;
      it.req_type    = 1'b1;
      it.vaddr       = $urandom;
      it.access_kind = 2'($urandom_range(0, 3));
      it.priv_level  = 2'($urandom_range(0, 3));
      it.pte_word    = w;
      return it;
   endfunction

   function automatic logic [31:0] pick_ram_addr();
      bit [63:0] o;
      if (ram_len == 33'h0 || $urandom_range(0, 9) == 0) return $urandom;
      o = {$urandom, $urandom};
      o = o % {31'h0, ram_len};
      return ram_lo + o[31:0];
   endfunction

   function automatic logic [31:0] make_pte(input logic lvl);
      logic [31:0] a;
      logic [9:0]  f;
      logic [2:0]  rwx;
      int          r;
      a = pick_ram_addr();
      f = 10'($urandom);
      r = $urandom_range(0, 99);
      if (r < 4) return $urandom;
      if ((lvl && r < 45) || (!lvl && r < 8))
         return {$urandom_range(0, 3) == 0 ? 2'($urandom) : 2'b00, a[31:12],
                 f[9:4], 3'b000, 1'b1};
      case ($urandom_range(0, 5))
         0: rwx = 3'b001;
         1: rwx = 3'b011;
         2: rwx = 3'b100;
         3: rwx = 3'b101;
         4: rwx = 3'b111;
         default: rwx = 3'($urandom);
      endcase
      f[3:1] = rwx;
      f[0]   = ($urandom_range(0, 19) != 0);
      if (lvl)
         return {2'($urandom), a[31:22],
                 $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'h0, f};
      return {2'($urandom), a[31:12], f};
   endfunction

   task automatic send_item(input req_type_type it);
      req_item <= it;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_item(it);
      sent++;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (exp_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [32:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_XLATE: xlate_on = val[0];
         CSR_ROOT:  pt_root  = val[21:0];
         CSR_SUM:   sum_en   = val[0];
         CSR_MXR:   mxr_en   = val[0];
         CSR_BASE:  ram_lo   = val[31:0];
         CSR_SIZE:  ram_len  = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic x, input logic [21:0] rt, input logic s,
                             input logic m, input logic [31:0] b, input logic [32:0] sz);
      wait_quiet();
      csr_write(CSR_XLATE, {32'h0, x});
      csr_write(CSR_ROOT, {11'h0, rt});
      csr_write(CSR_SUM, {32'h0, s});
      csr_write(CSR_MXR, {32'h0, m});
      csr_write(CSR_BASE, {1'b0, b});
      csr_write(CSR_SIZE, sz);
   endtask

   // ---------------- tests
   task automatic test_bare_mode();
      send_item(xl_item(32'h8000_1234, AK_FETCH, PL_USER));
      send_item(xl_item(32'h0000_1000, AK_FETCH, 2'd1));
      send_item(xl_item(32'h0000_1000, AK_LOAD, PL_USER));
      send_item(xl_item(32'hFFFF_FFFF, AK_STORE, 2'd1));
      send_item(xl_item(32'h87FF_FFFF, 2'd3, 2'd3));
      send_item(pte_item($urandom));   // no walk running
   endtask

   task automatic test_walks();
      // superpage fetch, then TLB hit, then user hit on supervisor page
      send_item(xl_item(32'h0040_0123, AK_FETCH, 2'd1));
      send_item(pte_item({12'h200, 10'h0, 10'h009}));
      send_item(xl_item(32'h0040_0456, AK_FETCH, 2'd1));
      send_item(xl_item(32'h0040_0456, AK_FETCH, PL_USER));
      // two-level user store, dirty set
      send_item(xl_item(32'h0080_5678, AK_STORE, PL_USER));
      send_item(pte_item({2'b00, 20'h80020, 10'h001}));
      send_item(pte_item({2'b11, 20'h80030, 10'h017}));
      // invalid, write without read, non-leaf at bottom, misaligned superpage
      send_item(xl_item(32'h0123_4000, AK_LOAD, 2'd1));
      send_item(pte_item(32'h0));
      send_item(xl_item(32'h0123_4000, AK_STORE, 2'd1));
      send_item(pte_item(32'h0000_0005));
      send_item(xl_item(32'h0123_4000, AK_FETCH, PL_USER));
      send_item(pte_item({2'b00, 20'h80020, 10'h001}));
      send_item(pte_item({2'b00, 20'h80021, 10'h001}));
      send_item(xl_item(32'h0123_4000, AK_LOAD, 2'd1));
      send_item(pte_item({12'h200, 10'h001, 10'h00B}));
      // new translate drops a running walk; leaf outside RAM goes to MMIO
      send_item(xl_item(32'hFFC0_0000, AK_LOAD, 2'd1));
      send_item(xl_item(32'h0000_0FFC, 2'd3, PL_USER));
      send_item(pte_item({12'h000, 10'h0, 10'h017}));
      send_item(xl_item(32'h0000_0FFC, AK_FETCH, PL_USER));
      send_item(pte_item({12'h000, 10'h0, 10'h019}));
      send_item(xl_item(32'h1234_5678, AK_LOAD, PL_MACH));
   endtask

   task automatic random_phase(input int target);
      logic [31:0] va;
      int          guard;
      while (sent < target) begin
         if (fetch_pool.size() != 0 && $urandom_range(0, 2) == 0) begin
            va = {fetch_pool[$urandom_range(0, fetch_pool.size() - 1)][31:12],
                  12'($urandom)};
            send_item(xl_item(va, AK_FETCH, 2'($urandom_range(0, 3))));
         end else begin
            va = ($urandom_range(0, 3) == 0) ? {$urandom_range(0, 3) == 0 ? 10'h3FF : 10'h0,
                                               22'($urandom)} : $urandom;
            send_item(xl_item(va, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));
            if (fetch_pool.size() > 15) void'(fetch_pool.pop_front());
            fetch_pool.push_back(va);
         end
         guard = 0;
         while (walking && guard < 3) begin
            guard++;
            case ($urandom_range(0, 19))
               0: send_item(xl_item($urandom, 2'($urandom_range(0, 3)),
                                    2'($urandom_range(0, 3))));
               1: send_item(pte_item($urandom));
               default: send_item(pte_item(make_pte(wlevel)));
            endcase
         end
         if ($urandom_range(0, 15) == 0) send_item(pte_item($urandom));
      end
   endtask

   task automatic test_random();
      logic [31:0] b;
      set_config(1'b1, 22'h80010, 1'b0, 1'b0, 32'h8000_0000, 33'h0800_0000);
      set_config(1'b1, 22'(pick_ram_addr() >> 12), 1'b0, 1'b0, 32'h8000_0000, 33'h0800_0000);
      random_phase(sent + 90);
      set_config(1'b1, 22'(pick_ram_addr() >> 12), 1'b1, 1'b1, 32'h8000_0000, 33'h0800_0000);
      random_phase(sent + 90);
      set_config(1'b1, 22'($urandom), 1'($urandom_range(0, 1)), 1'b0, 32'h0, 33'h1_0000_0000);
      random_phase(sent + 90);
      set_config(1'b1, 22'h3FFFFF, 1'b1, 1'b0, 32'hFFFF_F000, 33'h1000);
      random_phase(sent + 60);
      set_config(1'b1, 22'($urandom), 1'b0, 1'b1, 32'hFFFF_FFFF, 33'h0);
      random_phase(sent + 40);
      b = $urandom;
      set_config(1'b0, 22'($urandom), 1'b1, 1'b1, b, 33'($urandom));
      random_phase(sent + 40);
      set_config(1'b1, 22'h80010, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 32'h8000_0000, 33'h0800_0000);
      random_phase(ITEMS);
   endtask

   // ---------------- result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (exp_rsp_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", rsp_item);
         end else begin
            if (rsp_item !== exp_rsp_q[0]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %p actual %p", exp_rsp_q[0], rsp_item);
            end
            void'(exp_rsp_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      errors      = 0;
      sent        = 0;
      burst_left  = 4;
      idle_cycles = 0;
      for (int i = 0; i < NUM_TLB; i++) begin
         tlb_vpn[i]  = '0;
         tlb_perm[i] = '0;
         tlb_ppn[i]  = '0;
      end
      walking       = 1'b0;
      wlevel        = 1'b1;
      walk_va       = '0;
      walk_kind     = '0;
      walk_priv     = '0;
      walk_pte_addr = '0;
      xlate_on      = 1'b0;
      pt_root       = '0;
      sum_en        = 1'b0;
      mxr_en        = 1'b0;
      ram_lo        = 32'h8000_0000;
      ram_len       = 33'h0800_0000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bare_mode();
      set_config(1'b1, 22'h80010, 1'b0, 1'b0, 32'h8000_0000, 33'h0800_0000);
      test_walks();
      test_random();
      wait_quiet();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
